// File: hw/rtl/tvfsm_pkg.sv
// ----------------------------------------------------------------------------
// tvfsm_pkg: shared types and helpers for the TMR voter
// Beat payload structs, supervisor mode codes and small compare functions.
// ----------------------------------------------------------------------------
package tvfsm_pkg;

    // Sample width (signed Q11.4 at 16 bits) and register widths
    localparam int SAMPLE_WIDTH = 16;
    localparam int THR_WIDTH    = 16;
    localparam int LIMIT_WIDTH  = 4;
    localparam int CNT_WIDTH    = 4;
    localparam int FAULT_WIDTH  = 2;
    localparam int CODE_WIDTH   = 2;

    // Register reset values
    localparam logic [THR_WIDTH-1:0]   THR_RESET   = THR_WIDTH'(80);
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(3);

    // APB register map
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam logic REG_AGREE_THRESHOLD = 1'b0;
    localparam logic REG_REC_LIMIT       = 1'b1;

    // Reciprocal of 3 for magnitudes below 2^(SAMPLE_WIDTH+1)
    localparam int MAG_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int SUM_WIDTH  = SAMPLE_WIDTH + 2;
    localparam int PROD_WIDTH = 2 * SAMPLE_WIDTH + 2;
    localparam logic [MAG_WIDTH-1:0] DIV3_MUL =
        MAG_WIDTH'(((64'd1 << (SAMPLE_WIDTH + 2)) / 64'd3) + 64'd1);

    // Fault totals
    localparam logic [FAULT_WIDTH-1:0] FAULTS_NONE = 2'd0;
    localparam logic [FAULT_WIDTH-1:0] FAULTS_ONE  = 2'd1;
    localparam logic [FAULT_WIDTH-1:0] FAULTS_ALL  = 2'd3;

    // Mode codes as seen on the result beat
    localparam logic [CODE_WIDTH-1:0] MODE_CODE_NOMINAL    = 2'd0;
    localparam logic [CODE_WIDTH-1:0] MODE_CODE_DEGRADED   = 2'd1;
    localparam logic [CODE_WIDTH-1:0] MODE_CODE_SAFE       = 2'd2;
    localparam logic [CODE_WIDTH-1:0] MODE_CODE_RECOVERING = 2'd3;

    // Supervisor states
    typedef enum logic [3:0] {
        ST_NOMINAL    = 4'b0001,
        ST_DEGRADED   = 4'b0010,
        ST_SAFE       = 4'b0100,
        ST_RECOVERING = 4'b1000
    } t_mode;

    // Input beat
    typedef struct packed {
        logic                            kind;
        logic signed [SAMPLE_WIDTH-1:0]  sample_a;
        logic signed [SAMPLE_WIDTH-1:0]  sample_b;
        logic signed [SAMPLE_WIDTH-1:0]  sample_c;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  voted_value;
        logic                            fault_a;
        logic                            fault_b;
        logic                            fault_c;
        logic [FAULT_WIDTH-1:0]          fault_total;
        logic [CODE_WIDTH-1:0]           mode_after;
    } t_out_item;

    // Request from the pipeline to the supervisor
    typedef struct packed {
        logic                   update;
        logic                   op_reset;
        logic [FAULT_WIDTH-1:0] faults;
    } t_sup_req;

    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_OP_RESET = 1'b1;

    // Map a state onto its result code
    function automatic logic [CODE_WIDTH-1:0] mode_code(input t_mode m);
        logic [CODE_WIDTH-1:0] c;
        case (m)
            ST_NOMINAL:    c = MODE_CODE_NOMINAL;
            ST_DEGRADED:   c = MODE_CODE_DEGRADED;
            ST_SAFE:       c = MODE_CODE_SAFE;
            ST_RECOVERING: c = MODE_CODE_RECOVERING;
            default:       c = MODE_CODE_SAFE;
        endcase
        return c;
    endfunction

    // Two readings agree when |x - y| <= thr, difference at full precision
    function automatic logic agree(input logic signed [SAMPLE_WIDTH-1:0] x,
                                   input logic signed [SAMPLE_WIDTH-1:0] y,
                                   input logic [THR_WIDTH-1:0]           thr);
        logic [SAMPLE_WIDTH:0] d;
        logic [SAMPLE_WIDTH:0] m;
        d = {x[SAMPLE_WIDTH-1], x} - {y[SAMPLE_WIDTH-1], y};
        m = d[SAMPLE_WIDTH] ? (~d + 1'b1) : d;
        return m <= (SAMPLE_WIDTH + 1)'(thr);
    endfunction

    // Median of three signed readings
    function automatic logic signed [SAMPLE_WIDTH-1:0] median3(
        input logic signed [SAMPLE_WIDTH-1:0] a,
        input logic signed [SAMPLE_WIDTH-1:0] b,
        input logic signed [SAMPLE_WIDTH-1:0] c);
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
        logic signed [SAMPLE_WIDTH-1:0] r;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            r = lo;
        end else if (c >= hi) begin
            r = hi;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/tvfsm_sup.sv
// ----------------------------------------------------------------------------
// tvfsm_sup: fault supervisor
// Four-state mode machine with a recovery sample counter; advances once per
// sample and on operator reset, and reports the mode after the update.
// ----------------------------------------------------------------------------
module tvfsm_sup
    import tvfsm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_sup_req               i_req,
    input  logic [LIMIT_WIDTH-1:0] i_limit,
    output logic [CODE_WIDTH-1:0]  o_mode_code
);

    t_mode                r_mode;
    t_mode                n_mode;
    logic [CNT_WIDTH-1:0] r_count;
    logic [CNT_WIDTH-1:0] n_count;
    logic [CNT_WIDTH-1:0] count_inc;

    assign count_inc = r_count + 1'b1;

    // Next state for the beat leaving the pipeline
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        if (i_req.update) begin
            if (i_req.op_reset) begin
                // Operator reset only acts from degraded or safe
                if (r_mode == ST_DEGRADED || r_mode == ST_SAFE) begin
                    n_mode  = ST_RECOVERING;
                    n_count = '0;
                end
            end else begin
                case (r_mode)
                    ST_NOMINAL, ST_DEGRADED: begin
                        if (i_req.faults == FAULTS_NONE) begin
                            n_mode = ST_NOMINAL;
                        end else if (i_req.faults == FAULTS_ONE) begin
                            n_mode = ST_DEGRADED;
                        end else begin
                            n_mode = ST_SAFE;
                        end
                    end
                    ST_SAFE: begin
                        n_mode = ST_SAFE;
                    end
                    ST_RECOVERING: begin
                        n_count = count_inc;
                        if (count_inc >= i_limit) begin
                            n_mode = ST_SAFE;
                        end else if (i_req.faults == FAULTS_NONE) begin
                            n_mode  = ST_NOMINAL;
                            n_count = '0;
                        end else if (i_req.faults == FAULTS_ONE) begin
                            n_mode  = ST_DEGRADED;
                            n_count = '0;
                        end else begin
                            n_mode = ST_SAFE;
                        end
                    end
                    default: begin
                        n_mode = ST_SAFE;
                    end
                endcase
            end
        end
    end

    // Hold mode and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ST_NOMINAL;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    assign o_mode_code = mode_code(n_mode);

endmodule

// File: hw/rtl/tmr_voter_fault_state_machine_top.sv
// ----------------------------------------------------------------------------
// tmr_voter_fault_state_machine_top: triple redundant sample voter
// Votes three readings per beat, flags faulty sensors and runs the supervisor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries either a sample
//   triple or an operator reset command. Every sample beat yields exactly one
//   result beat on (o_out_valid / i_out_stall / o_out); an operator reset
//   beat yields none but updates the supervisor in stream order.
//   Registers agree threshold (0x0) and recovery sample limit (0x4) are on the
//   APB port; the user must write them only while idle; no check enforces it.
//   Path: a result passes the input register, agree compare, sum and median,
//   multiply by 1/3 and halve, then the output register. Throughput: one beat
//   per cycle while nothing stalls; each stage holds one beat and the stall
//   ripples back only through stages that are full.
//   The supervisor state is updated as a beat leaves the multiply stage.
//   Reset: synchronous, active low; clears the pipeline, puts the supervisor
//   in nominal with a zero count and restores the register defaults.
//   Receiver stall: the result holds in the output register while the
//   earlier stages keep filling; o_in_stall rises once all are occupied.
// ----------------------------------------------------------------------------
module tmr_voter_fault_state_machine_top
    import tvfsm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_WIDTH-1:0]   r_thr;
    logic [LIMIT_WIDTH-1:0] r_limit;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_AGREE_THRESHOLD) begin
                r_thr <= pwdata[THR_WIDTH-1:0];
            end else begin
                r_limit <= pwdata[LIMIT_WIDTH-1:0];
            end
        end
    end

    // Read back
    always_comb begin
        if (paddr[2] == REG_REC_LIMIT) begin
            prdata = APB_DATA_WIDTH'(r_limit);
        end else begin
            prdata = APB_DATA_WIDTH'(r_thr);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    // stage A: input register
    logic                           r_a_vld;
    t_in_item                       r_a;
    // stage B: agree flags
    logic                           r_b_vld;
    logic                           r_b_kind;
    logic signed [SAMPLE_WIDTH-1:0] r_b_sa;
    logic signed [SAMPLE_WIDTH-1:0] r_b_sb;
    logic signed [SAMPLE_WIDTH-1:0] r_b_sc;
    logic [2:0]                     r_b_ok;
    // stage C: sum magnitude and median
    logic                           r_c_vld;
    logic                           r_c_kind;
    logic [2:0]                     r_c_ok;
    logic                           r_c_neg;
    logic [MAG_WIDTH-1:0]           r_c_mag;
    logic signed [SAMPLE_WIDTH-1:0] r_c_med;
    // stage D: quotients
    logic                           r_d_vld;
    logic                           r_d_kind;
    logic [2:0]                     r_d_ok;
    logic                           r_d_neg;
    logic [SAMPLE_WIDTH-1:0]        r_d_q3;
    logic [SAMPLE_WIDTH-1:0]        r_d_q2;
    logic signed [SAMPLE_WIDTH-1:0] r_d_med;
    // stage E: output register
    logic                           r_out_vld;
    t_out_item                      r_out;

    // ------------------------------------------------------------------
    // Flow control: each stage moves when the next one has room
    // ------------------------------------------------------------------
    logic out_free;
    logic d_go, d_rdy;
    logic c_go, c_rdy;
    logic b_go, b_rdy;
    logic a_go, a_rdy;
    logic in_take;

    assign out_free = !r_out_vld || !i_out_stall;
    assign d_go     = r_d_vld && (r_d_kind == KIND_OP_RESET || out_free);
    assign d_rdy    = !r_d_vld || d_go;
    assign c_go     = r_c_vld && d_rdy;
    assign c_rdy    = !r_c_vld || c_go;
    assign b_go     = r_b_vld && c_rdy;
    assign b_rdy    = !r_b_vld || b_go;
    assign a_go     = r_a_vld && b_rdy;
    assign a_rdy    = !r_a_vld || a_go;
    assign in_take  = i_in_valid && a_rdy;

    assign o_in_stall = !a_rdy;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_a_vld <= i_in_valid;
            end
            if (b_rdy) begin
                r_b_vld <= a_go;
            end
            if (c_rdy) begin
                r_c_vld <= b_go;
            end
            if (d_rdy) begin
                r_d_vld <= c_go;
            end
            if (d_go && r_d_kind == KIND_SAMPLE) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture the input beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a <= i_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: pairwise agreement, a reading is valid if it agrees with one
    // ------------------------------------------------------------------
    logic ag_ab, ag_ac, ag_bc;

    assign ag_ab = agree(r_a.sample_a, r_a.sample_b, r_thr);
    assign ag_ac = agree(r_a.sample_a, r_a.sample_c, r_thr);
    assign ag_bc = agree(r_a.sample_b, r_a.sample_c, r_thr);

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_kind <= r_a.kind;
            r_b_sa   <= r_a.sample_a;
            r_b_sb   <= r_a.sample_b;
            r_b_sc   <= r_a.sample_c;
            r_b_ok   <= {ag_ac || ag_bc, ag_ab || ag_bc, ag_ab || ag_ac};
        end
    end

    // ------------------------------------------------------------------
    // Stage C: sum of valid readings as sign and magnitude, plus median
    // ------------------------------------------------------------------
    logic signed [SUM_WIDTH-1:0] sum;
    logic [SUM_WIDTH-1:0]        sum_abs;

    always_comb begin
        sum = '0;
        if (r_b_ok[0]) begin
            sum = sum + SUM_WIDTH'(r_b_sa);
        end
        if (r_b_ok[1]) begin
            sum = sum + SUM_WIDTH'(r_b_sb);
        end
        if (r_b_ok[2]) begin
            sum = sum + SUM_WIDTH'(r_b_sc);
        end
        sum_abs = sum[SUM_WIDTH-1] ? SUM_WIDTH'(-sum) : SUM_WIDTH'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_c_kind <= r_b_kind;
            r_c_ok   <= r_b_ok;
            r_c_neg  <= sum[SUM_WIDTH-1];
            r_c_mag  <= sum_abs[MAG_WIDTH-1:0];
            r_c_med  <= median3(r_b_sa, r_b_sb, r_b_sc);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: divide magnitude by 3 (reciprocal) and by 2 (shift)
    // ------------------------------------------------------------------
    logic [PROD_WIDTH-1:0] prod;

    assign prod = PROD_WIDTH'(r_c_mag) * PROD_WIDTH'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (c_go) begin
            r_d_kind <= r_c_kind;
            r_d_ok   <= r_c_ok;
            r_d_neg  <= r_c_neg;
            r_d_q3   <= prod[PROD_WIDTH-1:SUM_WIDTH];
            r_d_q2   <= r_c_mag[MAG_WIDTH-1:1];
            r_d_med  <= r_c_med;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: select the vote, update the supervisor, load the result
    // ------------------------------------------------------------------
    logic                    none_ok;
    logic                    all_ok;
    logic [FAULT_WIDTH-1:0]  faults;
    logic [SAMPLE_WIDTH-1:0] q_sel;
    logic [SAMPLE_WIDTH-1:0] mean;
    logic [CODE_WIDTH-1:0]   mode_next;
    t_sup_req                sup_req;

    assign none_ok = (r_d_ok == 3'b000);
    assign all_ok  = (r_d_ok == 3'b111);
    assign q_sel   = all_ok ? r_d_q3 : r_d_q2;
    assign mean    = r_d_neg ? (~q_sel + 1'b1) : q_sel;

    always_comb begin
        if (all_ok) begin
            faults = FAULTS_NONE;
        end else if (none_ok) begin
            faults = FAULTS_ALL;
        end else begin
            faults = FAULTS_ONE;
        end
    end

    assign sup_req.update   = d_go;
    assign sup_req.op_reset = (r_d_kind == KIND_OP_RESET);
    assign sup_req.faults   = faults;

    tvfsm_sup u_sup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (sup_req),
        .i_limit     (r_limit),
        .o_mode_code (mode_next)
    );

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (d_go && r_d_kind == KIND_SAMPLE) begin
            r_out.voted_value <= none_ok ? r_d_med : $signed(mean);
            r_out.fault_a     <= !r_d_ok[0];
            r_out.fault_b     <= !r_d_ok[1];
            r_out.fault_c     <= !r_d_ok[2];
            r_out.fault_total <= faults;
            r_out.mode_after  <= mode_next;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // A sample never leaves the supervisor in recovering
    a_no_recovering_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.mode_after != MODE_CODE_RECOVERING)
        else $error("result reports recovering mode");

    // All sensors faulty always forces safe mode
    a_all_fault_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.fault_total == FAULTS_ALL |->
            o_out.mode_after == MODE_CODE_SAFE)
        else $error("triple fault without safe mode");

    // Clean vote never lands in degraded
    a_clean_not_degraded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.fault_total == FAULTS_NONE |->
            !o_out.fault_a && !o_out.fault_b && !o_out.fault_c &&
            o_out.mode_after != MODE_CODE_DEGRADED)
        else $error("clean vote with fault flags or degraded mode");

    // Exactly one sensor flagged when the total is one
    a_single_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.fault_total == FAULTS_ONE |->
            $onehot({o_out.fault_a, o_out.fault_b, o_out.fault_c}))
        else $error("fault total disagrees with fault flags");
`endif

endmodule
